[rtl/per_group_exec_rate_limiter_assert.svh]
// Assertion macros shared by the rate limiter RTL.
`ifndef PER_GROUP_EXEC_RATE_LIMITER_ASSERT_SVH
`define PER_GROUP_EXEC_RATE_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PGRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pgrl_pkg.sv]
// Package with the types, constants and codes of the per-group exec rate limiter.
`default_nettype none

package pgrl_pkg;

  // Table geometry.
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths.
  localparam int KEY_W  = 64;
  localparam int TIME_W = 64;
  localparam int LIM_W  = 32;
  localparam int WIN_W  = 40;

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic [WIN_W-1:0] WIN_RESET = 40'd1000000000;
  // Register index decoded from paddr[3] (registers sit on 8-byte steps).
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Item modes.
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Largest total count; the count saturates here.
  localparam logic [LIM_W-1:0] COUNT_MAX = '1;

  // Result reason codes.
  typedef enum logic [2:0] {
    RSN_NO_ENTRY = 3'd0,
    RSN_ALLOWED  = 3'd1,
    RSN_PRIOR    = 3'd2,
    RSN_KILL     = 3'd3,
    RSN_TOTAL    = 3'd4,
    RSN_RATE     = 3'd5,
    RSN_WRITTEN  = 3'd6,
    RSN_FULL     = 3'd7
  } reason_t;

  // Input transaction payload.
  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  group_id;
    logic [TIME_W-1:0] now_ns;
    logic              prior_denied;
    logic              new_kill_switch;
    logic [LIM_W-1:0]  new_total_limit;
    logic [LIM_W-1:0]  new_rate_limit;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic    denied;
    reason_t reason;
  } out_item_t;

  // Table lookup result for the item in the input stage.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              kill;
    logic [LIM_W-1:0]  tot_lim;
    logic [LIM_W-1:0]  rate_lim;
    logic              cnt_valid;
    logic [LIM_W-1:0]  total;
    logic [TIME_W-1:0] wstart;
    logic [LIM_W-1:0]  wcount;
  } lookup_t;

  // Table update command produced by the decision logic.
  typedef struct packed {
    logic              lim_we;
    logic              alloc;
    logic              cnt_we;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic              kill;
    logic [LIM_W-1:0]  tot_lim;
    logic [LIM_W-1:0]  rate_lim;
    logic [LIM_W-1:0]  total;
    logic [TIME_W-1:0] wstart;
    logic [LIM_W-1:0]  wcount;
  } upd_t;

endpackage

`default_nettype wire

[rtl/pgrl_cfg.sv]
// APB-style configuration register block holding the window length.
`default_nettype none

module pgrl_cfg
  import pgrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [WIN_W-1:0]      win_len
);

  logic [WIN_W-1:0] win_len_r;
  logic             wr_en;

  // A write completes in the access phase; the port never waits.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WIN_RESET;
    end else if (wr_en && (paddr[3] == REG_WINDOW_LENGTH)) begin
      win_len_r <= pwdata[WIN_W-1:0];
    end
  end

  // Read data; addresses beyond the register list read as zero.
  always_comb begin
    if (paddr[3] == REG_WINDOW_LENGTH) begin
      prdata = {{(CFG_DATA_W-WIN_W){1'b0}}, win_len_r};
    end else begin
      prdata = '0;
    end
  end

  assign win_len = win_len_r;

endmodule

`default_nettype wire

[rtl/pgrl_table.sv]
// Group table: entry storage, key match, free-slot search and update port.
`default_nettype none
`include "per_group_exec_rate_limiter_assert.svh"

module pgrl_table
  import pgrl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic             en,
  input  wire upd_t             upd,
  output lookup_t               lkp
);

  // Valid bits per slot; reset clears them.
  logic [ENTRIES-1:0] ent_valid_r;
  logic [ENTRIES-1:0] cnt_valid_r;

  // Entry contents; undefined until written.
  logic [KEY_W-1:0]  key_r      [ENTRIES];
  logic              kill_r     [ENTRIES];
  logic [LIM_W-1:0]  tot_lim_r  [ENTRIES];
  logic [LIM_W-1:0]  rate_lim_r [ENTRIES];
  logic [LIM_W-1:0]  total_r    [ENTRIES];
  logic [TIME_W-1:0] wstart_r   [ENTRIES];
  logic [LIM_W-1:0]  wcount_r   [ENTRIES];

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;

  // Lowest matching valid slot and lowest free slot.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (ent_valid_r[i] && (key_r[i] == key)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!ent_valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Contents of the matching slot.
  always_comb begin
    lkp.hit       = hit;
    lkp.hit_idx   = hit_idx;
    lkp.free_ok   = free_ok;
    lkp.free_idx  = free_idx;
    lkp.kill      = kill_r[hit_idx];
    lkp.tot_lim   = tot_lim_r[hit_idx];
    lkp.rate_lim  = rate_lim_r[hit_idx];
    lkp.cnt_valid = cnt_valid_r[hit_idx];
    lkp.total     = total_r[hit_idx];
    lkp.wstart    = wstart_r[hit_idx];
    lkp.wcount    = wcount_r[hit_idx];
  end

  // Valid bits: allocation makes an entry with no counter, a check creates it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      cnt_valid_r <= '0;
    end else if (en) begin
      if (upd.alloc) begin
        ent_valid_r[upd.idx] <= 1'b1;
        cnt_valid_r[upd.idx] <= 1'b0;
      end
      if (upd.cnt_we) begin
        cnt_valid_r[upd.idx] <= 1'b1;
      end
    end
  end

  // Entry payload writes.
  always_ff @(posedge clk) begin
    if (en && upd.alloc) begin
      key_r[upd.idx] <= upd.key;
    end
    if (en && upd.lim_we) begin
      kill_r[upd.idx]     <= upd.kill;
      tot_lim_r[upd.idx]  <= upd.tot_lim;
      rate_lim_r[upd.idx] <= upd.rate_lim;
    end
    if (en && upd.cnt_we) begin
      total_r[upd.idx]  <= upd.total;
      wstart_r[upd.idx] <= upd.wstart;
      wcount_r[upd.idx] <= upd.wcount;
    end
  end

  // A counter only ever exists for a live entry.
  `PGRL_ASSERT_IMP(a_cnt_needs_entry, clk, rst_n, 1'b1, (cnt_valid_r & ~ent_valid_r) == '0, "counter valid without entry")
  // An allocated slot is live and has no counter yet.
  `PGRL_ASSERT_NXT(a_alloc_fresh, clk, rst_n, en && upd.alloc, ent_valid_r[$past(upd.idx)] && !cnt_valid_r[$past(upd.idx)], "allocation did not take")

endmodule

`default_nettype wire

[rtl/pgrl_decide.sv]
// Decision logic: works out the result and the table update for one item.
`default_nettype none

module pgrl_decide
  import pgrl_pkg::*;
(
  input  wire in_item_t         item,
  input  wire lookup_t          lkp,
  input  wire logic [WIN_W-1:0] win_len,
  output out_item_t             res,
  output upd_t                  upd
);

  logic [LIM_W-1:0]  eff_total;
  logic [TIME_W-1:0] eff_wstart;
  logic [LIM_W-1:0]  eff_wcount;
  logic [TIME_W-1:0] elapsed;
  logic              restart;
  logic [TIME_W-1:0] nxt_wstart;
  logic [LIM_W-1:0]  nxt_wcount;

  // Counter values as seen by this check; a missing counter starts fresh.
  always_comb begin
    eff_total  = lkp.cnt_valid ? lkp.total  : '0;
    eff_wstart = lkp.cnt_valid ? lkp.wstart : item.now_ns;
    eff_wcount = lkp.cnt_valid ? lkp.wcount : '0;
    elapsed    = item.now_ns - eff_wstart;
    restart    = elapsed >= {{(TIME_W-WIN_W){1'b0}}, win_len};
    nxt_wstart = restart ? item.now_ns : eff_wstart;
    nxt_wcount = restart ? '0 : eff_wcount;
  end

  // Result and update selection.
  always_comb begin
    res.denied   = 1'b0;
    res.reason   = RSN_NO_ENTRY;
    upd.lim_we   = 1'b0;
    upd.alloc    = 1'b0;
    upd.cnt_we   = 1'b0;
    upd.idx      = lkp.hit_idx;
    upd.key      = item.group_id;
    upd.kill     = item.new_kill_switch;
    upd.tot_lim  = item.new_total_limit;
    upd.rate_lim = item.new_rate_limit;
    upd.total    = eff_total;
    upd.wstart   = eff_wstart;
    upd.wcount   = eff_wcount;

    if (item.mode == MODE_WRITE) begin
      // Limits write: update in place, else take the lowest free slot.
      if (lkp.hit) begin
        upd.lim_we = 1'b1;
        res.reason = RSN_WRITTEN;
      end else if (lkp.free_ok) begin
        upd.idx    = lkp.free_idx;
        upd.alloc  = 1'b1;
        upd.lim_we = 1'b1;
        res.reason = RSN_WRITTEN;
      end else begin
        res.reason = RSN_FULL;
      end
    end else if (item.prior_denied) begin
      res.denied = 1'b1;
      res.reason = RSN_PRIOR;
    end else if (!lkp.hit) begin
      res.reason = RSN_NO_ENTRY;
    end else if (lkp.kill) begin
      res.denied = 1'b1;
      res.reason = RSN_KILL;
    end else begin
      // Past the kill switch the counter exists from here on.
      upd.cnt_we = 1'b1;
      if ((lkp.tot_lim != '0) && (eff_total >= lkp.tot_lim)) begin
        res.denied = 1'b1;
        res.reason = RSN_TOTAL;
      end else if ((lkp.rate_lim != '0) && (nxt_wcount >= lkp.rate_lim)) begin
        // The window restart is kept even though the exec is denied.
        upd.wstart = nxt_wstart;
        upd.wcount = nxt_wcount;
        res.denied = 1'b1;
        res.reason = RSN_RATE;
      end else begin
        if (lkp.rate_lim != '0) begin
          upd.wstart = nxt_wstart;
          upd.wcount = nxt_wcount + LIM_W'(1);
        end
        if (eff_total != COUNT_MAX) begin
          upd.total = eff_total + LIM_W'(1);
        end
        res.reason = RSN_ALLOWED;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/per_group_exec_rate_limiter.sv]
// Top level of the per-group exec rate limiter.
`default_nettype none
`include "per_group_exec_rate_limiter_assert.svh"

// Fixed-window exec rate limiter over a table of ENTRIES groups. Each input
// transaction either writes a group's kill switch and limits (mode 1) or checks
// one exec request (mode 0), and yields exactly one result transaction carrying
// denied and a reason code. An accepted transaction is held in an input
// register, from which the table is looked up and the decision is made
// combinationally; when it advances, the table is updated and the result is
// loaded into the output register, so one transaction per cycle is sustained
// while the output is not stalled. That rate rests on the read-modify-write of
// the matching table slot being done as the transaction advances. The input
// side keeps accepting while a result waits, as long as the input register is
// empty. Slot valid bits are cleared by reset at once, so the block takes
// transactions as soon as reset is released. The window length register is
// at byte address 0 of the 64-bit configuration port and resets to one second.

module per_group_exec_rate_limiter
  import pgrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic       stage_valid_r;
  logic       stage_valid_nxt;
  in_item_t   stage_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;

  logic             advance;
  logic             in_accept;
  logic [WIN_W-1:0] win_len;
  lookup_t          lkp;
  upd_t             upd;
  out_item_t        res;

  // Configuration registers.
  pgrl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .win_len (win_len)
  );

  // Group table.
  pgrl_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (stage_item_r.group_id),
    .en    (advance),
    .upd   (upd),
    .lkp   (lkp)
  );

  // Decision logic between the input and output registers.
  pgrl_decide u_decide (
    .item    (stage_item_r),
    .lkp     (lkp),
    .win_len (win_len),
    .res     (res),
    .upd     (upd)
  );

  // Flow control: the staged transaction moves when the output register is
  // empty or being drained.
  assign advance   = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = stage_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_accept) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // The denied flag agrees with the reason code.
  `PGRL_ASSERT_IMP(a_deny_matches_reason, clk, rst_n, out_valid_r, out_item_r.denied == ((out_item_r.reason == RSN_PRIOR) || (out_item_r.reason == RSN_KILL) || (out_item_r.reason == RSN_TOTAL) || (out_item_r.reason == RSN_RATE)), "denied flag disagrees with reason")
  // A blocked output holds the staged transaction in place.
  `PGRL_ASSERT_NXT(a_stage_holds, clk, rst_n, stage_valid_r && out_valid_r && out_stall, stage_valid_r && $stable(stage_item_r), "staged transaction lost under stall")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the per-group exec rate limiter: stimulus, predictor and checks.

module tb_top;
  import pgrl_pkg::*;

  localparam int KEY_POOL    = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_PHASES  = 6;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 3'b000};
  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  // Predictor view of one table slot.
  typedef struct packed {
    bit              in_use;
    bit [KEY_W-1:0]  key;
    bit              kill;
    bit [LIM_W-1:0]  total_cap;
    bit [LIM_W-1:0]  rate_cap;
    bit              counting;
    bit [LIM_W-1:0]  total;
    bit [TIME_W-1:0] win_start;
    bit [LIM_W-1:0]  win_count;
  } group_slot_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor state and the stores between stimulus, driver and monitor.
  group_slot_t     groups [ENTRIES];
  bit [WIN_W-1:0]  win_len;
  in_item_t        pending_q [$];
  out_item_t       verdict_q [$];
  out_item_t       want_item;
  bit [KEY_W-1:0]  key_pool [KEY_POOL];
  bit [TIME_W-1:0] clock_ns = 64'd5000;

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  bit  hold_request  = 1'b0;
  bit  hold_taken    = 1'b0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;
  int  mismatch_count = 0;
  int  config_errs    = 0;
  int  results_seen   = 0;
  int  reason_tally [8];

  per_group_exec_rate_limiter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the verdict for one accepted transaction and updates the table copy.
  function automatic out_item_t judge_request(input in_item_t it);
    out_item_t       verdict;
    int              slot;
    bit [TIME_W-1:0] elapsed;
    slot = -1;
    verdict.denied = 1'b0;
    verdict.reason = RSN_ALLOWED;
    // The lowest slot holding the key wins.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (groups[i].in_use && groups[i].key == it.group_id) slot = i;
    end
    if (it.mode == MODE_WRITE) begin
      // A new group takes the lowest free slot, without a counter.
      if (slot < 0) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!groups[i].in_use) slot = i;
        end
        if (slot >= 0) begin
          groups[slot] = '0;
          groups[slot].in_use = 1'b1;
          groups[slot].key = it.group_id;
        end
      end
      if (slot < 0) begin
        verdict.reason = RSN_FULL;
      end else begin
        groups[slot].kill = it.new_kill_switch;
        groups[slot].total_cap = it.new_total_limit;
        groups[slot].rate_cap = it.new_rate_limit;
        verdict.reason = RSN_WRITTEN;
      end
    end else if (it.prior_denied) begin
      verdict.denied = 1'b1;
      verdict.reason = RSN_PRIOR;
    end else if (slot < 0) begin
      verdict.reason = RSN_NO_ENTRY;
    end else if (groups[slot].kill) begin
      verdict.denied = 1'b1;
      verdict.reason = RSN_KILL;
    end else begin
      // The counter set starts at the time of the group's first counted check.
      if (!groups[slot].counting) begin
        groups[slot].counting = 1'b1;
        groups[slot].total = '0;
        groups[slot].win_start = it.now_ns;
        groups[slot].win_count = '0;
      end
      if (groups[slot].total_cap != 0 && groups[slot].total >= groups[slot].total_cap) begin
        verdict.denied = 1'b1;
        verdict.reason = RSN_TOTAL;
      end else begin
        // The window restart sticks even when the request is then refused.
        if (groups[slot].rate_cap != 0) begin
          elapsed = it.now_ns - groups[slot].win_start;
          if (elapsed >= TIME_W'(win_len)) begin
            groups[slot].win_start = it.now_ns;
            groups[slot].win_count = '0;
          end
          if (groups[slot].win_count >= groups[slot].rate_cap) begin
            verdict.denied = 1'b1;
            verdict.reason = RSN_RATE;
          end else begin
            groups[slot].win_count = groups[slot].win_count + 1;
          end
        end
        if (!verdict.denied && groups[slot].total != '1) begin
          groups[slot].total = groups[slot].total + 1;
        end
      end
    end
    return verdict;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random filler so that fields unused by a mode still toggle.
  function automatic in_item_t noise_item();
    bit [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic queue_check(input bit [KEY_W-1:0] key, input bit [TIME_W-1:0] now,
                             input bit prior);
    in_item_t it;
    it = noise_item();
    it.mode = MODE_CHECK;
    it.group_id = key;
    it.now_ns = now;
    it.prior_denied = prior;
    pending_q.push_back(it);
  endtask

  task automatic queue_write(input bit [KEY_W-1:0] key, input bit kill,
                             input bit [LIM_W-1:0] tot, input bit [LIM_W-1:0] rate);
    in_item_t it;
    it = noise_item();
    it.mode = MODE_WRITE;
    it.group_id = key;
    it.new_kill_switch = kill;
    it.new_total_limit = tot;
    it.new_rate_limit = rate;
    pending_q.push_back(it);
  endtask

  // Moves the stimulus clock: repeats, short steps, window edges, wraps and steps back.
  function automatic bit [TIME_W-1:0] next_now();
    bit [TIME_W-1:0] span;
    int              pick;
    span = TIME_W'(win_len);
    pick = $urandom_range(99);
    if (pick >= 96) clock_ns -= TIME_W'($urandom_range(1, 50));
    else if (pick >= 90) clock_ns += rand64();
    else if (pick >= 82) clock_ns += span - 1;
    else if (pick >= 72) clock_ns += span;
    else if (pick >= 30) clock_ns += rand64() % (span / 4 + 1);
    return clock_ns;
  endfunction

  function automatic bit [KEY_W-1:0] pick_key(input int fresh_pct);
    if ($urandom_range(99) < fresh_pct) return rand64();
    return key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  function automatic bit [LIM_W-1:0] pick_cap(input bit for_rate);
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return '0;
    if (pick < 80) return for_rate ? $urandom_range(1, 4) : $urandom_range(1, 12);
    if (pick < 93) return $urandom;
    return '1;
  endfunction

  // Writes the window length and reads it back; only called while the block is idle.
  task automatic set_window(input bit [WIN_W-1:0] len);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= WINDOW_ADDR;
    cfg_pwdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    win_len = len;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[WIN_W-1:0] !== len) begin
      config_errs++;
      $display("window length readback: expected %0d, got %0d", len, cfg_prdata[WIN_W-1:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Looks at the queues between edges, once every update of the edge has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: presents queued transactions and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(judge_request(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result transaction with the oldest verdict and drives stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result %0d: denied %0b reason %0d", results_seen,
                     out_data.denied, out_data.reason);
          end
          mismatch_count++;
        end else begin
          want_item = verdict_q.pop_front();
          reason_tally[want_item.reason]++;
          if (out_data.denied !== want_item.denied || out_data.reason !== want_item.reason) begin
            if (mismatch_count < 10) begin
              $display("result %0d: expected denied %0b reason %0d, got denied %0b reason %0d",
                       results_seen, want_item.denied, want_item.reason,
                       out_data.denied, out_data.reason);
            end
            mismatch_count++;
          end
        end
      end
      // One long hold-off when asked, otherwise random stalls.
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    bit [WIN_W-1:0] phase_win;
    int             phase_items;
    int             slots_used;
    int             denials;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < KEY_POOL; i++) key_pool[i] = rand64();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_window(40'd1000);

    // Directed opening: missing group, prior denial, caps, kill switch, time wrap.
    queue_check(key_pool[0], clock_ns, 1'b0);
    queue_check(key_pool[0], clock_ns, 1'b1);
    queue_write(key_pool[0], 1'b0, 32'd3, 32'd2);
    queue_check(key_pool[0], 64'd5000, 1'b0);
    queue_check(key_pool[0], 64'd5000, 1'b0);
    queue_check(key_pool[0], 64'd5999, 1'b0);
    queue_check(key_pool[0], 64'd6000, 1'b0);
    queue_check(key_pool[0], 64'd6000, 1'b0);
    queue_check(key_pool[0], 64'd6000, 1'b1);
    queue_write(key_pool[1], 1'b1, '1, '1);
    queue_check(key_pool[1], 64'd6000, 1'b0);
    queue_write(key_pool[1], 1'b0, '0, '0);
    queue_check(key_pool[1], '1, 1'b0);
    queue_check(key_pool[1], '0, 1'b0);
    queue_write(key_pool[2], 1'b0, '1, 32'd1);
    queue_check(key_pool[2], 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    queue_check(key_pool[2], 64'd5, 1'b0);
    queue_check(key_pool[2], 64'hFFFF_FFFF_FFFF_FFF0 + 64'd1000, 1'b0);
    // Rewriting limits keeps the running counter of the group.
    queue_write(key_pool[0], 1'b0, '0, 32'd1);
    queue_check(key_pool[0], 64'd6500, 1'b0);
    queue_check(key_pool[0], 64'd7000, 1'b0);
    clock_ns = 64'd7000;

    // Random phases, each with its own window length and idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      phase_items = 300;
      case (p)
        0: begin
          phase_win = 40'd1000;
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          phase_win = 40'd1;
          send_idle_pct = 48;
          stall_pct = 0;
        end
        2: begin
          phase_win = WIN_MAX;
          send_idle_pct = 0;
          stall_pct = 48;
        end
        3: begin
          phase_win = WIN_W'($urandom_range(1, 5000));
          send_idle_pct = 9;
          stall_pct = 9;
        end
        4: begin
          phase_win = 40'd100;
          send_idle_pct = 0;
          stall_pct = 0;
          hold_request = 1'b1;
        end
        default: begin
          phase_win = 40'd20;
          send_idle_pct = 9;
          stall_pct = 48;
          phase_items = 350;
        end
      endcase
      set_window(phase_win);
      for (int n = 0; n < phase_items; n++) begin
        if ($urandom_range(99) < 25) begin
          queue_write(pick_key(10), $urandom_range(99) < 12, pick_cap(1'b0), pick_cap(1'b1));
        end else begin
          queue_check(pick_key(12), next_now(), $urandom_range(99) < 8);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0d expected results never arrived", verdict_q.size());
    end
    slots_used = 0;
    for (int i = 0; i < ENTRIES; i++) slots_used += groups[i].in_use;
    denials = reason_tally[RSN_PRIOR] + reason_tally[RSN_KILL] + reason_tally[RSN_TOTAL]
              + reason_tally[RSN_RATE];
    $display("Checked %0d results over %0d window settings: %0d allowed, %0d denied, %0d unknown.",
             results_seen, NUM_PHASES + 1, reason_tally[RSN_ALLOWED], denials,
             reason_tally[RSN_NO_ENTRY]);
    $display("Writes stored %0d, refused on a full table %0d; %0d slots in use at the end.",
             reason_tally[RSN_WRITTEN], reason_tally[RSN_FULL], slots_used);
    if (mismatch_count == 0 && config_errs == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
